// ----- src/hai_pkg.sv -----
// Shared types, sizes and tables for the Hessian accumulate and invert block.
// Used by hai_front, hai_solver, hai_rsp_q and hessian_accumulate_invert.
`default_nettype none
package hai_pkg;

   localparam int MAX_SAMPLES = 256;
   localparam int SMP_W       = $clog2(MAX_SAMPLES + 1);
   // matrix entry, cofactor and determinant widths
   localparam int MW          = 32 + $clog2(MAX_SAMPLES);
   localparam int CW          = 2 * MW + 1;
   localparam int DW          = 3 * MW + 2;
   localparam int MAX_SHIFT   = 56;
   localparam int NW          = CW + MAX_SHIFT;
   localparam int QW          = 65;
   localparam int NSTEPS      = 21;
   localparam int STEP_W      = $clog2(NSTEPS);
   localparam int MBIT_W      = $clog2(MW);
   localparam int DBIT_W      = $clog2(NW);
   localparam int SHIFT_W     = $clog2(MAX_SHIFT + 1);

   localparam logic [3:0] LAST_ENTRY = 4'd8;

   typedef struct packed {
      logic signed [MW-1:0] sum_xx;
      logic signed [MW-1:0] sum_xy;
      logic signed [MW-1:0] sum_x;
      logic signed [MW-1:0] sum_yy;
      logic signed [MW-1:0] sum_y;
      logic [SMP_W-1:0]     sample_count;
      logic                 overflow_seen;
   } batch_type;

   typedef struct packed {
      logic [3:0]  entry_index;
      logic [63:0] entry_value;
      logic        singular;
      logic        saturated;
      logic        sample_overflow;
      logic        last_entry;
   } result_type;

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_MUL, S_ACC, S_DSET, S_DIV, S_EMIT
   } solver_state_type;

   typedef enum logic [1:0] {
      OP_LOAD, OP_ADD, OP_SUB
   } acc_op_type;

   typedef struct packed {
      logic [3:0] a_sel;
      logic       b_cof;
      logic [3:0] b_sel;
      acc_op_type op;
      logic       store;
      logic       to_det;
      logic [3:0] dest;
   } step_type;

   function automatic step_type mk_step(input logic [3:0] a, input logic cof,
                                        input logic [3:0] b, input acc_op_type op,
                                        input logic st, input logic det,
                                        input logic [3:0] dest);
      step_type s;
      s.a_sel  = a;
      s.b_cof  = cof;
      s.b_sel  = b;
      s.op     = op;
      s.store  = st;
      s.to_det = det;
      s.dest   = dest;
      return s;
   endfunction

   // cofactors as a*b - c*d, then det = m0*c0 + m1*c1 + m2*c2
   function automatic step_type step_rom(input logic [STEP_W-1:0] idx);
      step_type s;
      case (idx)
         5'd0:  s = mk_step(4'd4, 1'b0, 4'd8, OP_LOAD, 1'b0, 1'b0, 4'd0);
         5'd1:  s = mk_step(4'd5, 1'b0, 4'd7, OP_SUB,  1'b1, 1'b0, 4'd0);
         5'd2:  s = mk_step(4'd5, 1'b0, 4'd6, OP_LOAD, 1'b0, 1'b0, 4'd1);
         5'd3:  s = mk_step(4'd3, 1'b0, 4'd8, OP_SUB,  1'b1, 1'b0, 4'd1);
         5'd4:  s = mk_step(4'd3, 1'b0, 4'd7, OP_LOAD, 1'b0, 1'b0, 4'd2);
         5'd5:  s = mk_step(4'd4, 1'b0, 4'd6, OP_SUB,  1'b1, 1'b0, 4'd2);
         5'd6:  s = mk_step(4'd2, 1'b0, 4'd7, OP_LOAD, 1'b0, 1'b0, 4'd3);
         5'd7:  s = mk_step(4'd1, 1'b0, 4'd8, OP_SUB,  1'b1, 1'b0, 4'd3);
         5'd8:  s = mk_step(4'd0, 1'b0, 4'd8, OP_LOAD, 1'b0, 1'b0, 4'd4);
         5'd9:  s = mk_step(4'd2, 1'b0, 4'd6, OP_SUB,  1'b1, 1'b0, 4'd4);
         5'd10: s = mk_step(4'd1, 1'b0, 4'd6, OP_LOAD, 1'b0, 1'b0, 4'd5);
         5'd11: s = mk_step(4'd0, 1'b0, 4'd7, OP_SUB,  1'b1, 1'b0, 4'd5);
         5'd12: s = mk_step(4'd1, 1'b0, 4'd5, OP_LOAD, 1'b0, 1'b0, 4'd6);
         5'd13: s = mk_step(4'd2, 1'b0, 4'd4, OP_SUB,  1'b1, 1'b0, 4'd6);
         5'd14: s = mk_step(4'd2, 1'b0, 4'd3, OP_LOAD, 1'b0, 1'b0, 4'd7);
         5'd15: s = mk_step(4'd0, 1'b0, 4'd5, OP_SUB,  1'b1, 1'b0, 4'd7);
         5'd16: s = mk_step(4'd0, 1'b0, 4'd4, OP_LOAD, 1'b0, 1'b0, 4'd8);
         5'd17: s = mk_step(4'd1, 1'b0, 4'd3, OP_SUB,  1'b1, 1'b0, 4'd8);
         5'd18: s = mk_step(4'd0, 1'b1, 4'd0, OP_LOAD, 1'b0, 1'b0, 4'd0);
         5'd19: s = mk_step(4'd1, 1'b1, 4'd1, OP_ADD,  1'b0, 1'b0, 4'd0);
         5'd20: s = mk_step(4'd2, 1'b1, 4'd2, OP_ADD,  1'b1, 1'b1, 4'd0);
         default: s = mk_step(4'd0, 1'b0, 4'd0, OP_LOAD, 1'b0, 1'b0, 4'd0);
      endcase
      return s;
   endfunction

   // rows and columns 0,1 carry an extra factor 16 each
   function automatic logic [SHIFT_W-1:0] entry_shift(input logic [3:0] k);
      logic [SHIFT_W-1:0] s;
      case (k)
         4'd0, 4'd1, 4'd3, 4'd4: s = SHIFT_W'(56);
         4'd2, 4'd5, 4'd6, 4'd7: s = SHIFT_W'(52);
         default:                s = SHIFT_W'(48);
      endcase
      return s;
   endfunction

endpackage
`default_nettype wire

// ----- src/hai_front.sv -----
// Front part: accumulates gradient sums per batch and queues finished batches.
// Depends on hai_pkg.
`default_nettype none
module hai_front import hai_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic signed [15:0] req_grad_x,
   input  wire logic signed [15:0] req_grad_y,
   input  wire logic               req_batch_end,
   input  wire logic               push,
   output logic                    full,
   output logic                    batch_valid,
   output batch_type               batch,
   input  wire logic               batch_pop
);

   logic signed [MW-1:0] sxx_ff, sxy_ff, sx_ff, syy_ff, sy_ff;
   logic signed [MW-1:0] sxx_in, sxy_in, sx_in, syy_in, sy_in;
   logic [SMP_W-1:0]     cnt_ff, cnt_in;
   logic                 ovf_ff, ovf_in;
   logic signed [31:0]   pxx, pxy, pyy;
   batch_type            snap;
   logic                 accept, take, q_push;

   batch_type            q_mem [2];
   logic                 wr_ptr_ff, rd_ptr_ff;
   logic [1:0]           q_cnt_ff;

   assign accept = push & ~full;
   assign take   = cnt_ff < SMP_W'(MAX_SAMPLES);
   assign pxx    = req_grad_x * req_grad_x;
   assign pxy    = req_grad_x * req_grad_y;
   assign pyy    = req_grad_y * req_grad_y;

   always_comb begin
      sxx_in = sxx_ff;
      sxy_in = sxy_ff;
      sx_in  = sx_ff;
      syy_in = syy_ff;
      sy_in  = sy_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (take) begin
         sxx_in = sxx_ff + MW'(pxx);
         sxy_in = sxy_ff + MW'(pxy);
         sx_in  = sx_ff + MW'(req_grad_x);
         syy_in = syy_ff + MW'(pyy);
         sy_in  = sy_ff + MW'(req_grad_y);
         cnt_in = cnt_ff + 1'b1;
      end else begin
         ovf_in = 1'b1;
      end
   end

   always_comb begin
      snap.sum_xx        = sxx_in;
      snap.sum_xy        = sxy_in;
      snap.sum_x         = sx_in;
      snap.sum_yy        = syy_in;
      snap.sum_y         = sy_in;
      snap.sample_count  = cnt_in;
      snap.overflow_seen = ovf_in;
   end

   assign q_push = accept & req_batch_end;

   always_ff @(posedge clock) begin
      if (reset || q_push) begin
         sxx_ff <= '0;
         sxy_ff <= '0;
         sx_ff  <= '0;
         syy_ff <= '0;
         sy_ff  <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (accept) begin
         sxx_ff <= sxx_in;
         sxy_ff <= sxy_in;
         sx_ff  <= sx_in;
         syy_ff <= syy_in;
         sy_ff  <= sy_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

   // batch queue toward the solver
   always_ff @(posedge clock) begin
      if (q_push) begin
         q_mem[wr_ptr_ff] <= snap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         q_cnt_ff  <= '0;
      end else begin
         if (q_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (batch_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         q_cnt_ff <= q_cnt_ff + {1'b0, q_push} - {1'b0, batch_pop};
      end
   end

   assign full        = q_cnt_ff == 2'd2;
   assign batch_valid = q_cnt_ff != 2'd0;
   assign batch       = q_mem[rd_ptr_ff];

endmodule
`default_nettype wire

// ----- src/hai_solver.sv -----
// Back part: cofactors and determinant on a shared shift-add multiplier,
// then, if det is nonzero, one restoring division per inverse entry. Depends on hai_pkg.
`default_nettype none
module hai_solver import hai_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       batch_valid,
   input  wire batch_type  batch,
   output logic            batch_pop,
   output logic            res_valid,
   output result_type      res,
   input  wire logic       res_ready
);

   solver_state_type       state_ff, state_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   batch_type              snap_ff, snap_in;
   logic signed [MW-1:0]   a_ff, a_in;
   logic signed [CW-1:0]   b_ff, b_in;
   logic signed [DW-1:0]   p_ff, p_in, t_ff, t_in, det_ff, det_in, t_new;
   logic [MBIT_W-1:0]      mbit_ff, mbit_in;
   logic signed [CW-1:0]   num_ff [9];
   logic signed [CW-1:0]   num_rd;
   logic [3:0]             rd_idx;
   logic                   num_we;
   logic [3:0]             entry_ff, entry_in;
   logic [NW-1:0]          dvd_ff, dvd_in;
   logic [DW-1:0]          dvs_ff, dvs_in, r_ff, r_in;
   logic [QW-1:0]          q_ff, q_in;
   logic                   qovf_ff, qovf_in, neg_ff, neg_in, sing_ff, sing_in;
   logic [DBIT_W-1:0]      dbit_ff, dbit_in;
   step_type               st;
   logic [CW-1:0]          num_mag;
   logic [DW:0]            r2, diff;
   logic                   ge, big;
   logic [63:0]            q64;

   function automatic logic signed [MW-1:0] m_entry(input batch_type b,
                                                   input logic [3:0] idx);
      logic signed [MW-1:0] v;
      case (idx)
         4'd0:       v = b.sum_xx;
         4'd1, 4'd3: v = b.sum_xy;
         4'd2, 4'd6: v = b.sum_x;
         4'd4:       v = b.sum_yy;
         4'd5, 4'd7: v = b.sum_y;
         default:    v = MW'(b.sample_count);
      endcase
      return v;
   endfunction

   assign st      = step_rom(step_ff);
   assign rd_idx  = (state_ff == S_LOAD) ? st.b_sel : entry_ff;
   assign num_rd  = num_ff[rd_idx];
   assign num_mag = num_rd[CW-1] ? CW'(-num_rd) : num_rd;
   assign r2      = {r_ff, dvd_ff[NW-1]};
   assign diff    = r2 - {1'b0, dvs_ff};
   assign ge      = r2 >= {1'b0, dvs_ff};
   assign big     = qovf_ff | q_ff[QW-1];
   assign q64     = q_ff[63:0];

   always_comb begin
      case (st.op)
         OP_ADD:  t_new = t_ff + p_ff;
         OP_SUB:  t_new = t_ff - p_ff;
         default: t_new = p_ff;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      snap_in   = snap_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      p_in      = p_ff;
      t_in      = t_ff;
      det_in    = det_ff;
      mbit_in   = mbit_ff;
      entry_in  = entry_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      r_in      = r_ff;
      q_in      = q_ff;
      qovf_in   = qovf_ff;
      neg_in    = neg_ff;
      sing_in   = sing_ff;
      dbit_in   = dbit_ff;
      batch_pop = 1'b0;
      num_we    = 1'b0;
      res_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (batch_valid) begin
               snap_in   = batch;
               batch_pop = 1'b1;
               step_in   = '0;
               state_in  = S_LOAD;
            end
         end
         S_LOAD: begin
            a_in     = m_entry(snap_ff, st.a_sel);
            b_in     = st.b_cof ? num_rd : CW'(m_entry(snap_ff, st.b_sel));
            // sign bit of a weighs negative
            p_in     = a_in[MW-1] ? -DW'(b_in) : '0;
            mbit_in  = MBIT_W'(MW - 2);
            state_in = S_MUL;
         end
         S_MUL: begin
            p_in = (p_ff <<< 1) + (a_ff[mbit_ff] ? DW'(b_ff) : '0);
            if (mbit_ff == '0) begin
               state_in = S_ACC;
            end else begin
               mbit_in = mbit_ff - 1'b1;
            end
         end
         S_ACC: begin
            t_in = t_new;
            if (st.store) begin
               if (st.to_det) begin
                  det_in = t_new;
               end else begin
                  num_we = 1'b1;
               end
            end
            if (step_ff == STEP_W'(NSTEPS - 1)) begin
               entry_in = '0;
               state_in = S_DSET;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = S_LOAD;
            end
         end
         S_DSET: begin
            if (det_ff == '0) begin
               sing_in  = 1'b1;
               state_in = S_EMIT;
            end else begin
               sing_in  = 1'b0;
               neg_in   = num_rd[CW-1] ^ det_ff[DW-1];
               dvd_in   = NW'(num_mag) << entry_shift(entry_ff);
               dvs_in   = det_ff[DW-1] ? DW'(-det_ff) : det_ff;
               r_in     = '0;
               q_in     = '0;
               qovf_in  = 1'b0;
               dbit_in  = DBIT_W'(NW - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            r_in    = ge ? diff[DW-1:0] : r2[DW-1:0];
            q_in    = {q_ff[QW-2:0], ge};
            qovf_in = qovf_ff | q_ff[QW-1];
            dvd_in  = dvd_ff << 1;
            if (dbit_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               dbit_in = dbit_ff - 1'b1;
            end
         end
         S_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               if (entry_ff == LAST_ENTRY) begin
                  state_in = S_IDLE;
               end else begin
                  entry_in = entry_ff + 1'b1;
                  state_in = S_DSET;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      res.entry_index     = entry_ff;
      res.singular        = sing_ff;
      res.sample_overflow = snap_ff.overflow_seen;
      res.last_entry      = entry_ff == LAST_ENTRY;
      if (sing_ff) begin
         res.saturated   = 1'b0;
         res.entry_value = '0;
      end else if (!neg_ff) begin
         res.saturated   = big | q64[63];
         res.entry_value = res.saturated ? 64'h7FFF_FFFF_FFFF_FFFF : q64;
      end else begin
         res.saturated   = big | (q64[63] & (|q64[62:0]));
         res.entry_value = res.saturated ? 64'h8000_0000_0000_0000 : -q64;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      snap_ff  <= snap_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      p_ff     <= p_in;
      t_ff     <= t_in;
      det_ff   <= det_in;
      mbit_ff  <= mbit_in;
      entry_ff <= entry_in;
      dvd_ff   <= dvd_in;
      dvs_ff   <= dvs_in;
      r_ff     <= r_in;
      q_ff     <= q_in;
      qovf_ff  <= qovf_in;
      neg_ff   <= neg_in;
      sing_ff  <= sing_in;
      dbit_ff  <= dbit_in;
      if (num_we) begin
         num_ff[st.dest] <= t_new[CW-1:0];
      end
   end

   a_entry_range: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> entry_ff <= LAST_ENTRY)
      else $error("entry index past the last entry");

   a_run_ends: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready && res.last_entry) |=> state_ff == S_IDLE)
      else $error("solver did not return to idle after the last entry");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      batch_pop |-> (state_ff == S_IDLE && batch_valid))
      else $error("batch popped outside idle");

   a_det_then_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC && st.store && st.to_det) |=> state_ff == S_DSET)
      else $error("determinant stored but division did not start");

endmodule
`default_nettype wire

// ----- src/hai_rsp_q.sv -----
// Two-entry result queue between the solver and the result ports.
// Depends on hai_pkg.
`default_nettype none
module hai_rsp_q import hai_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       wr_valid,
   input  wire result_type wr_data,
   output logic            wr_ready,
   output logic            empty,
   input  wire logic       pop,
   output result_type      rd_data
);

   result_type mem [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       do_wr, do_rd;

   assign wr_ready = cnt_ff != 2'd2;
   assign empty    = cnt_ff == 2'd0;
   assign do_wr    = wr_valid & wr_ready;
   assign do_rd    = pop & ~empty;
   assign rd_data  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_rd) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         cnt_ff <= cnt_ff + {1'b0, do_wr} - {1'b0, do_rd};
      end
   end

endmodule
`default_nettype wire

// ----- src/hessian_accumulate_invert.sv -----
// Top level: gradient accumulator front, batch queue, inverse solver, result queue.
// Depends on hai_pkg, hai_front, hai_solver, hai_rsp_q.
//
//   channel   direction  handshake     payload
//   req_      in         push / full   grad_x, grad_y, batch_end
//   rsp_      out        pop / empty   entry_index, entry_value, singular,
//                                      saturated, sample_overflow, last_entry
//
// Samples are taken one per cycle while full is low; full rises only while two finished batches wait.
// Per batch the solver spends 21 multiplies on cofactors and determinant, then one
// division per inverse entry (9 in all) unless the determinant is zero.
// The multiplier is bit-serial and the divider is a restoring divider.
// Reset is synchronous and clears all queues and the accumulators.
// A stalled result side holds the solver in its emit state; the front keeps accepting until its batch queue is full.
`default_nettype none
module hessian_accumulate_invert import hai_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic signed [15:0] req_grad_x,
   input  wire logic signed [15:0] req_grad_y,
   input  wire logic               req_batch_end,
   input  wire logic               push,
   output logic                    full,
   output logic [3:0]              rsp_entry_index,
   output logic signed [63:0]      rsp_entry_value,
   output logic                    rsp_singular,
   output logic                    rsp_saturated,
   output logic                    rsp_sample_overflow,
   output logic                    rsp_last_entry,
   output logic                    empty,
   input  wire logic               pop
);

   logic       batch_valid, batch_pop, res_valid, res_ready;
   batch_type  batch;
   result_type res, rd_data;

   hai_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_grad_x    (req_grad_x),
      .req_grad_y    (req_grad_y),
      .req_batch_end (req_batch_end),
      .push          (push),
      .full          (full),
      .batch_valid   (batch_valid),
      .batch         (batch),
      .batch_pop     (batch_pop)
   );

   hai_solver u_solver (
      .clock       (clock),
      .reset       (reset),
      .batch_valid (batch_valid),
      .batch       (batch),
      .batch_pop   (batch_pop),
      .res_valid   (res_valid),
      .res         (res),
      .res_ready   (res_ready)
   );

   hai_rsp_q u_rsp_q (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (res_valid),
      .wr_data  (res),
      .wr_ready (res_ready),
      .empty    (empty),
      .pop      (pop),
      .rd_data  (rd_data)
   );

   assign rsp_entry_index     = rd_data.entry_index;
   assign rsp_entry_value     = rd_data.entry_value;
   assign rsp_singular        = rd_data.singular;
   assign rsp_saturated       = rd_data.saturated;
   assign rsp_sample_overflow = rd_data.sample_overflow;
   assign rsp_last_entry      = rd_data.last_entry;

endmodule
`default_nettype wire

// ----- sim/tb_hessian_accumulate_invert.sv -----
// Testbench for hessian_accumulate_invert: streams gradient batches and checks every
// inverse entry against a wide-integer cofactor/determinant predictor.
// Depends on hai_pkg and the RTL under src/.
`timescale 1ns / 100ps
module tb_hessian_accumulate_invert;
   import hai_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int HOLD_CYCLES    = 8000;

   typedef logic signed [255:0] big_type;

   typedef struct {
      logic signed [15:0] gx;
      logic signed [15:0] gy;
      bit                 last_s;
      bit                 typed_sing;
   } sample_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic signed [15:0] req_grad_x = '0;
   logic signed [15:0] req_grad_y = '0;
   logic               req_batch_end = 1'b0;
   logic               push = 1'b0;
   logic               full;
   logic [3:0]         rsp_entry_index;
   logic signed [63:0] rsp_entry_value;
   logic               rsp_singular;
   logic               rsp_saturated;
   logic               rsp_sample_overflow;
   logic               rsp_last_entry;
   logic               empty;
   logic               pop = 1'b0;

   sample_type stim_q[$];
   result_type inverse_q[$];
   longint     acc_xx, acc_xy, acc_x, acc_yy, acc_y;
   int         acc_count;
   bit         acc_ovf;
   int         sent = 0;
   int         phase = 0;
   bit         failed = 1'b0;
   bit         send_done = 1'b0;
   bit         held = 1'b0;
   int         idle_cnt = 0;

   hessian_accumulate_invert uut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic big_type cross_diff(big_type a, big_type b, big_type c, big_type d);
      return a * b - c * d;
   endfunction

   task automatic clear_sums();
      acc_xx = 0; acc_xy = 0; acc_x = 0; acc_yy = 0; acc_y = 0;
      acc_count = 0;
      acc_ovf = 1'b0;
   endtask

   // take in one sample; on batch end queue the nine inverse entries
   task automatic predict_inverse(input sample_type s);
      big_type    m[9];
      big_type    cof[9];
      big_type    det, num, q;
      big_type    hi, lo;
      result_type r;
      int         shift;
      hi = big_type'(64'sh7FFF_FFFF_FFFF_FFFF);
      lo = -hi - 1;
      if (acc_count < MAX_SAMPLES) begin
         acc_xx += longint'(s.gx) * longint'(s.gx);
         acc_xy += longint'(s.gx) * longint'(s.gy);
         acc_x  += longint'(s.gx);
         acc_yy += longint'(s.gy) * longint'(s.gy);
         acc_y  += longint'(s.gy);
         acc_count++;
      end else begin
         acc_ovf = 1'b1;
      end
      if (!s.last_s) return;
      m[0] = big_type'(acc_xx); m[1] = big_type'(acc_xy); m[2] = big_type'(acc_x);
      m[3] = m[1];              m[4] = big_type'(acc_yy); m[5] = big_type'(acc_y);
      m[6] = m[2];              m[7] = m[5];              m[8] = big_type'(acc_count);
      cof[0] = cross_diff(m[4], m[8], m[5], m[7]);
      cof[1] = cross_diff(m[5], m[6], m[3], m[8]);
      cof[2] = cross_diff(m[3], m[7], m[4], m[6]);
      cof[3] = cross_diff(m[2], m[7], m[1], m[8]);
      cof[4] = cross_diff(m[0], m[8], m[2], m[6]);
      cof[5] = cross_diff(m[1], m[6], m[0], m[7]);
      cof[6] = cross_diff(m[1], m[5], m[2], m[4]);
      cof[7] = cross_diff(m[2], m[3], m[0], m[5]);
      cof[8] = cross_diff(m[0], m[4], m[1], m[3]);
      det = m[0] * cof[0] + m[1] * cof[1] + m[2] * cof[2];
      for (int k = 0; k < 9; k++) begin
         r.entry_index     = 4'(k);
         r.entry_value     = '0;
         r.singular        = (det == 0);
         r.saturated       = 1'b0;
         r.sample_overflow = acc_ovf;
         r.last_entry      = (4'(k) == LAST_ENTRY);
         if (det != 0) begin
            shift = 48 + ((k / 3) < 2 ? 4 : 0) + ((k % 3) < 2 ? 4 : 0);
            num = cof[k] <<< shift;
            q = num / det;
            if (q > hi) begin
               q = hi;
               r.saturated = 1'b1;
            end else if (q < lo) begin
               q = lo;
               r.saturated = 1'b1;
            end
            r.entry_value = q[63:0];
         end
         // rank-deficient batches: all zero, flagged singular
         if (s.typed_sing) begin
            r.entry_value = '0;
            r.singular    = 1'b1;
            r.saturated   = 1'b0;
         end
         inverse_q.push_back(r);
      end
      clear_sums();
   endtask

   task automatic add_item(input int gx, input int gy, input bit e, input bit ts);
      sample_type s;
      s.gx = 16'(gx);
      s.gy = 16'(gy);
      s.last_s = e;
      s.typed_sing = ts;
      stim_q.push_back(s);
   endtask

   task automatic build_stimulus();
      sample_type table_rows[$];
      int         len, kind, base_x, base_y;
      bit         long_done;
      table_rows = '{
         '{16'sd0, 16'sd0, 1'b1, 1'b1},
         '{16'sd32767, -16'sd32768, 1'b1, 1'b1},
         '{16'sd32767, 16'sd32767, 1'b0, 1'b0},
         '{-16'sd32768, -16'sd32768, 1'b0, 1'b0},
         '{-16'sd32768, 16'sd32767, 1'b0, 1'b0},
         '{16'sd32767, -16'sd32768, 1'b0, 1'b0},
         '{16'sd0, 16'sd0, 1'b1, 1'b0},
         '{16'sd1, 16'sd0, 1'b0, 1'b0},
         '{16'sd0, 16'sd1, 1'b0, 1'b0},
         '{16'sd0, 16'sd0, 1'b1, 1'b0},
         '{16'sd1, 16'sd1, 1'b0, 1'b1},
         '{16'sd2, 16'sd2, 1'b0, 1'b1},
         '{16'sd3, 16'sd3, 1'b1, 1'b1},
         '{16'sd5, -16'sd3, 1'b0, 1'b0},
         '{-16'sd7, 16'sd2, 1'b0, 1'b0},
         '{16'sd100, -16'sd200, 1'b0, 1'b0},
         '{-16'sd1, -16'sd1, 1'b1, 1'b0},
         '{16'sd0, 16'sd0, 1'b0, 1'b0},
         '{16'sd2000, 16'sd1, 1'b0, 1'b0},
         '{16'sd4000, 16'sd3, 1'b1, 1'b0},
         '{16'sh5555, -16'sh5556, 1'b0, 1'b0},
         '{-16'sh5556, 16'sh5555, 1'b0, 1'b0},
         '{-16'sd1, -16'sd1, 1'b1, 1'b0}
      };
      long_done = 1'b0;
      foreach (table_rows[i]) stim_q.push_back(table_rows[i]);
      while (stim_q.size() < 230) begin
         // one oversized batch to exercise the sample limit
         if (!long_done && stim_q.size() > 30) begin
            len = MAX_SAMPLES + 3;
            long_done = 1'b1;
         end else if ($urandom_range(9) == 0) len = $urandom_range(1, 2);
         else len = $urandom_range(3, 8);
         kind = $urandom_range(2);
         base_x = $urandom_range(4000) - 2000;
         base_y = $urandom_range(4000) - 2000;
         for (int i = 0; i < len; i++) begin
            case (kind)
               0: add_item($urandom_range(65535), $urandom_range(65535), i == len - 1, 0);
               1: add_item($urandom_range(16) - 8, $urandom_range(16) - 8, i == len - 1, 0);
               default: add_item(base_x * i + $urandom_range(2), base_y * i + $urandom_range(2),
                                 i == len - 1, 0);
            endcase
         end
      end
   endtask

   function automatic int sender_idle_pct();
      return (phase == 0) ? 18 : (phase == 1) ? 60 : 0;
   endfunction

   function automatic int receiver_idle_pct();
      return (phase == 0) ? 60 : (phase == 1) ? 18 : 0;
   endfunction

   // sender
   initial begin
      clear_sums();
      build_stimulus();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (sent < stim_q.size()) begin
         @(posedge clock);
         if (push && !full) begin
            predict_inverse(stim_q[sent]);
            sent++;
            phase = (sent < stim_q.size() / 3) ? 0 : (sent < 2 * stim_q.size() / 3) ? 1 : 2;
         end
         if (sent < stim_q.size() && $urandom_range(99) >= sender_idle_pct()) begin
            push          <= 1'b1;
            req_grad_x    <= stim_q[sent].gx;
            req_grad_y    <= stim_q[sent].gy;
            req_batch_end <= stim_q[sent].last_s;
         end else begin
            push <= 1'b0;
         end
      end
      send_done = 1'b1;
   end

   // receiver and checker
   initial begin
      result_type exp_r;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (pop && !empty) begin
            if (inverse_q.size() == 0) begin
               $error("unexpected entry index %0d", rsp_entry_index);
               failed = 1'b1;
            end else begin
               exp_r = inverse_q.pop_front();
               if (rsp_entry_index !== exp_r.entry_index) begin
                  $error("entry_index exp %0d got %0d", exp_r.entry_index, rsp_entry_index);
                  failed = 1'b1;
               end
               if (rsp_entry_value !== exp_r.entry_value) begin
                  $error("entry_value exp %h got %h", exp_r.entry_value, rsp_entry_value);
                  failed = 1'b1;
               end
               if (rsp_singular !== exp_r.singular) begin
                  $error("singular exp %0b got %0b", exp_r.singular, rsp_singular);
                  failed = 1'b1;
               end
               if (rsp_saturated !== exp_r.saturated) begin
                  $error("saturated exp %0b got %0b", exp_r.saturated, rsp_saturated);
                  failed = 1'b1;
               end
               if (rsp_sample_overflow !== exp_r.sample_overflow) begin
                  $error("sample_overflow exp %0b got %0b", exp_r.sample_overflow,
                         rsp_sample_overflow);
                  failed = 1'b1;
               end
               if (rsp_last_entry !== exp_r.last_entry) begin
                  $error("last_entry exp %0b got %0b", exp_r.last_entry, rsp_last_entry);
                  failed = 1'b1;
               end
            end
         end
         // hold off once for a long stretch so the input side backs up
         if (!held && sent >= 40) begin
            held = 1'b1;
            pop <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         pop <= ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   // watchdog: cycles with no accepted item on either side
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      wait (send_done);
      wait (inverse_q.size() == 0);
      repeat (100) @(posedge clock);
      if (!failed) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/hai_pkg.sv
src/hai_front.sv
src/hai_solver.sv
src/hai_rsp_q.sv
src/hessian_accumulate_invert.sv
sim/tb_hessian_accumulate_invert.sv
